/* rtl/core/sensor_frame_crc_check_convert_top_assert.svh */
// assertion macros for the sensor frame crc check and convert block
// expects clk and rst_n in the scope where a macro is used
`ifndef SENSOR_FRAME_CRC_CHECK_CONVERT_TOP_ASSERT_SVH
`define SENSOR_FRAME_CRC_CHECK_CONVERT_TOP_ASSERT_SVH

// same-cycle implication
`define SFCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfcc assertion failed");

// next-cycle implication
`define SFCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfcc assertion failed");

`endif

/* rtl/core/sfcc_pkg.sv */
// shared types, constants and the crc-8 step function
// no dependencies
package sfcc_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;

  localparam int PROD_T_W = 31;
  localparam int PROD_H_W = 30;

  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_BAD = 2'd1,
    STATUS_HUM_BAD  = 2'd2
  } sfcc_status_t;

  typedef struct packed {
    logic [15:0]         raw_t;
    logic [15:0]         raw_h;
    logic [PROD_T_W-1:0] prod_t;
    logic [PROD_H_W-1:0] prod_h;
    sfcc_status_t        status;
  } sfcc_meas_t;

  function automatic logic [7:0] sfcc_crc8(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/sfcc_if.sv */
// valid/ready channel interfaces for frame bytes and converted results
// no dependencies
interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface sfcc_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        raw_temperature;
  logic [15:0]        raw_humidity;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [1:0]         status;

  modport source (output valid, output raw_temperature, output raw_humidity,
                  output temperature_centi, output humidity_centi, output status,
                  input ready);
  modport sink (input valid, input raw_temperature, input raw_humidity,
                input temperature_centi, input humidity_centi, input status,
                output ready);
endinterface

/* rtl/core/sfcc_frame.sv */
// frame assembly, crc-8 checks and scaling products
// depends on sfcc_pkg
module sfcc_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_vld,
  input  logic [7:0]          s1_byte,
  input  logic                s1_start,
  output logic                s1_ready,
  output logic                s2_vld,
  output sfcc_pkg::sfcc_meas_t s2_meas,
  input  logic                s3_ready
);
  import sfcc_pkg::*;

  logic [2:0]   pos_r, pos_nxt, pos_cur;
  logic [7:0]   crc_r, crc_nxt;
  logic [15:0]  temp_r, temp_nxt;
  logic [15:0]  hum_r, hum_nxt;
  logic         tgood_r, tgood_nxt;
  logic         s2_vld_r, s2_vld_nxt;
  sfcc_meas_t   meas_r, meas_nxt;
  logic         take;
  logic         hgood;

  assign s1_ready = !s2_vld_r || s3_ready;
  assign take     = s1_vld && s1_ready;
  assign s2_vld   = s2_vld_r;
  assign s2_meas  = meas_r;

  always_comb begin
    pos_cur = s1_start ? POS_T_HI : pos_r;
    if (pos_cur > POS_H_CRC) begin
      pos_cur = POS_T_HI;
    end
  end

  assign hgood = (crc_r == s1_byte);

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    temp_nxt   = temp_r;
    hum_nxt    = hum_r;
    tgood_nxt  = tgood_r;
    s2_vld_nxt = s2_vld_r;
    meas_nxt   = meas_r;
    if (s3_ready) begin
      s2_vld_nxt = 1'b0;
    end
    if (take) begin
      pos_nxt = (pos_cur == POS_H_CRC) ? POS_T_HI : pos_cur + 3'd1;
      unique case (pos_cur)
        POS_T_HI: begin
          temp_nxt = {s1_byte, 8'h00};
          crc_nxt  = sfcc_crc8(CRC_INIT, s1_byte);
        end
        POS_T_LO: begin
          temp_nxt = {temp_r[15:8], s1_byte};
          crc_nxt  = sfcc_crc8(crc_r, s1_byte);
        end
        POS_T_CRC: begin
          tgood_nxt = (crc_r == s1_byte);
        end
        POS_H_HI: begin
          hum_nxt = {s1_byte, 8'h00};
          crc_nxt = sfcc_crc8(CRC_INIT, s1_byte);
        end
        POS_H_LO: begin
          hum_nxt = {hum_r[15:8], s1_byte};
          crc_nxt = sfcc_crc8(crc_r, s1_byte);
        end
        default: begin
          s2_vld_nxt      = 1'b1;
          meas_nxt.raw_t  = temp_r;
          meas_nxt.raw_h  = hum_r;
          meas_nxt.prod_t = PROD_T_W'(temp_r) * PROD_T_W'(TEMP_SPAN);
          meas_nxt.prod_h = PROD_H_W'(hum_r) * PROD_H_W'(HUM_SPAN);
          priority if (!tgood_r) begin
            meas_nxt.status = STATUS_TEMP_BAD;
          end else if (!hgood) begin
            meas_nxt.status = STATUS_HUM_BAD;
          end else begin
            meas_nxt.status = STATUS_OK;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_T_HI;
      crc_r    <= CRC_INIT;
      temp_r   <= '0;
      hum_r    <= '0;
      tgood_r  <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      temp_r   <= temp_nxt;
      hum_r    <= hum_nxt;
      tgood_r  <= tgood_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r <= meas_nxt;
  end

endmodule

/* rtl/core/sfcc_scale.sv */
// divide-by-full-scale correction and the result register
// depends on sfcc_pkg and sfcc_out_if
module sfcc_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s2_vld,
  input  sfcc_pkg::sfcc_meas_t s2_meas,
  output logic                 s3_ready,
  sfcc_out_if.source           out_chan
);
  import sfcc_pkg::*;

  logic        vld_r, vld_nxt;
  logic [15:0] raw_t_r, raw_h_r;
  logic [14:0] tc_r, tc_nxt;
  logic [13:0] hc_r, hc_nxt;
  logic [1:0]  st_r;
  logic        load;

  logic [14:0] qt, qt_c;
  logic [16:0] rt;
  logic [15:0] tdiff;
  logic [13:0] qh;
  logic [16:0] rh;

  assign s3_ready = !vld_r || out_chan.ready;
  assign load     = s2_vld && s3_ready;

  // p / 65535 = q + (lo + q >= 65535), with q = p >> 16
  always_comb begin
    qt     = s2_meas.prod_t[30:16];
    rt     = 17'(s2_meas.prod_t[15:0]) + 17'(qt);
    qt_c   = qt + 15'(rt >= 17'(FULL_SCALE));
    tdiff  = 16'(qt_c) - TEMP_OFFSET;
    tc_nxt = tdiff[14:0];
    qh     = s2_meas.prod_h[29:16];
    rh     = 17'(s2_meas.prod_h[15:0]) + 17'(qh);
    hc_nxt = qh + 14'(rh >= 17'(FULL_SCALE));
  end

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      raw_t_r <= s2_meas.raw_t;
      raw_h_r <= s2_meas.raw_h;
      tc_r    <= tc_nxt;
      hc_r    <= hc_nxt;
      st_r    <= s2_meas.status;
    end
  end

  assign out_chan.valid             = vld_r;
  assign out_chan.raw_temperature   = raw_t_r;
  assign out_chan.raw_humidity      = raw_h_r;
  assign out_chan.temperature_centi = $signed(tc_r);
  assign out_chan.humidity_centi    = hc_r;
  assign out_chan.status            = st_r;

endmodule

/* rtl/core/sensor_frame_crc_check_convert_top.sv */
// channel     | direction | payload
// in_chan     | sink      | data_byte, frame_start
// out_chan    | source    | raw_temperature, raw_humidity, temperature_centi,
//             |           | humidity_centi, status
// one byte request per cycle unless stalled; a result follows its sixth byte
// three register stages: input register, frame state with product register,
// result register after the divide correction
// the input and result registers decouple the two sides, so a stalled result
// does not stop byte intake until all stages are full
// synchronous active-low reset clears the frame position, crc and valid bits
// depends on sfcc_pkg, sfcc_if, sfcc_frame and sfcc_scale
module sensor_frame_crc_check_convert_top (
  input  logic      clk,
  input  logic      rst_n,
  sfcc_in_if.sink   in_chan,
  sfcc_out_if.source out_chan
);
  import sfcc_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       s1_ready;
  logic       s2_vld;
  sfcc_meas_t s2_meas;
  logic       s3_ready;
  logic       in_take;

  assign in_chan.ready = !in_vld_r || s1_ready;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (s1_ready) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_chan.data_byte;
      in_start_r <= in_chan.frame_start;
    end
  end

  sfcc_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_vld   (in_vld_r),
    .s1_byte  (in_byte_r),
    .s1_start (in_start_r),
    .s1_ready (s1_ready),
    .s2_vld   (s2_vld),
    .s2_meas  (s2_meas),
    .s3_ready (s3_ready)
  );

  sfcc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_vld   (s2_vld),
    .s2_meas  (s2_meas),
    .s3_ready (s3_ready),
    .out_chan (out_chan)
  );

endmodule

/* rtl/core/sfcc_chk.sv */
// port-level checker for the result channel, bound to the top level
// depends on sfcc_pkg and sensor_frame_crc_check_convert_top_assert.svh
`include "sensor_frame_crc_check_convert_top_assert.svh"

module sfcc_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        out_raw_temperature,
  input logic [15:0]        out_raw_humidity,
  input logic signed [14:0] out_temperature_centi,
  input logic [13:0]        out_humidity_centi,
  input logic [1:0]         out_status
);
  import sfcc_pkg::*;

  `SFCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SFCC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_raw_temperature) && $stable(out_raw_humidity) && $stable(out_status))
  `SFCC_ASSERT_NOW(a_temp_range, out_valid, out_temperature_centi >= -15'sd4500 && out_temperature_centi <= 15'sd13000)
  `SFCC_ASSERT_NOW(a_hum_status, out_valid, out_humidity_centi <= 14'd10000 && (out_status == STATUS_OK || out_status == STATUS_TEMP_BAD || out_status == STATUS_HUM_BAD))

endmodule

bind sensor_frame_crc_check_convert_top sfcc_chk u_sfcc_chk (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_chan.valid),
  .out_ready             (out_chan.ready),
  .out_raw_temperature   (out_chan.raw_temperature),
  .out_raw_humidity      (out_chan.raw_humidity),
  .out_temperature_centi (out_chan.temperature_centi),
  .out_humidity_centi    (out_chan.humidity_centi),
  .out_status            (out_chan.status)
);
